// ----- hdl/tsf_pkg.sv -----
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants of the time/count display formatter
// Holds the item structs, the pipeline word and the digit-to-segment decode.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int VALUE_W     = 32;
  localparam int NUM_DIGITS  = 10;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int BITS_PER_STG = 4;
  localparam int NUM_STG     = VALUE_W / BITS_PER_STG;

  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  localparam logic MODE_TIME  = 1'b0;
  localparam logic MODE_COUNT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
  } tsf_in_t;

  typedef struct packed {
    logic [7:0] left_segments;
    logic [7:0] middle_segments;
    logic [7:0] right_segments;
  } tsf_out_t;

  // word carried down the conversion pipeline
  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
  } tsf_work_t;

  function automatic logic [7:0] seg_of_digit(input logic [3:0] dig);
    logic [7:0] seg;
    case (dig)
      4'd0:    seg = 8'b00111111;
      4'd1:    seg = 8'b00000110;
      4'd2:    seg = 8'b01011011;
      4'd3:    seg = 8'b01001111;
      4'd4:    seg = 8'b01100110;
      4'd5:    seg = 8'b01101101;
      4'd6:    seg = 8'b01111101;
      4'd7:    seg = 8'b00000111;
      4'd8:    seg = 8'b01111111;
      4'd9:    seg = 8'b01101111;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

// ----- hdl/tsf_dabble_stage.sv -----
// ----------------------------------------------------------------------------
// tsf_dabble_stage: one registered binary-to-BCD conversion stage
// Shifts BITS_PER_STG binary bits into the BCD field (add-3 correction).
// ----------------------------------------------------------------------------
module tsf_dabble_stage
  import tsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  tsf_work_t up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output tsf_work_t dn_word
);

  logic      valid_r, valid_nxt;
  tsf_work_t word_r;
  tsf_work_t word_nxt;

  always_comb begin
    logic [BCD_W-1:0]   b;
    logic [VALUE_W-1:0] s;
    b = up_word.bcd;
    s = up_word.bin;
    for (int k = 0; k < BITS_PER_STG; k++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], s[VALUE_W-1]};
      s = {s[VALUE_W-2:0], 1'b0};
    end
    word_nxt.mode = up_word.mode;
    word_nxt.bin  = s;
    word_nxt.bcd  = b;
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ----- hdl/tsf_format.sv -----
// ----------------------------------------------------------------------------
// tsf_format: decimal digits to three seven-segment bytes
// Time mode: lead search, round to three digits, point placement.
// Count mode: saturate at 999, blank leading zeros.
// ----------------------------------------------------------------------------
module tsf_format
  import tsf_pkg::*;
(
  input  tsf_work_t word,
  output tsf_out_t  segs
);

  logic [3:0] dg [NUM_DIGITS];
  logic [2:0] lead;
  logic [2:0] lead_f;
  logic [15:0] win;
  logic [3:0] a, b, c, d;
  logic [3:0] ra, rb, rc;
  logic       inc, cy_b, cy_a, cy_out;
  logic [3:0] s0, s1, s2;
  logic [7:0] t0, t1, t2;
  logic       sat;
  logic [3:0] h, t, u;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dg[i] = word.bcd[BCD_W-1-4*i -: 4];
    end
  end

  // lead place: first nonzero among places 0-5, else 6
  always_comb begin
    lead = 3'd6;
    for (int i = 5; i >= 0; i--) begin
      if (dg[i] != 4'd0) begin
        lead = 3'(i);
      end
    end
  end

  assign win = word.bcd[6'd39 - {1'b0, lead, 2'b00} -: 16];
  assign a = win[15:12];
  assign b = win[11:8];
  assign c = win[7:4];
  assign d = win[3:0];

  // round to three places with carry
  always_comb begin
    inc    = (d > 4'd4);
    cy_b   = inc && (c == 4'd9);
    rc     = cy_b ? 4'd0 : c + {3'b000, inc};
    cy_a   = cy_b && (b == 4'd9);
    rb     = cy_a ? 4'd0 : b + {3'b000, cy_b};
    cy_out = cy_a && (a == 4'd9);
    ra     = cy_out ? 4'd0 : a + {3'b000, cy_a};
  end

  // final lead and shown digits; a carry from place one into place zero
  // still shows places one to three
  always_comb begin
    if (cy_out && (lead > 3'd1)) begin
      lead_f = lead - 3'd1;
      s0 = 4'd1;
      s1 = 4'd0;
      s2 = 4'd0;
    end else if (lead == 3'd0) begin
      lead_f = 3'd1;
      s0 = rb;
      s1 = rc;
      s2 = d;
    end else begin
      lead_f = lead;
      s0 = ra;
      s1 = rb;
      s2 = rc;
    end
  end

  always_comb begin
    t0 = seg_of_digit(s0);
    t1 = seg_of_digit(s1);
    t2 = seg_of_digit(s2);
    case (lead_f)
      3'd1: begin
        t2 = t2 | SEG_POINT;
      end
      3'd2: begin
        t1 = t1 | SEG_POINT;
        t2 = t2 | SEG_POINT;
      end
      3'd3: begin
        t0 = t0 | SEG_POINT;
        t2 = t2 | SEG_POINT;
      end
      3'd5: begin
        t1 = t1 | SEG_POINT;
      end
      3'd6: begin
        t0 = t0 | SEG_POINT;
      end
      default: begin
      end
    endcase
  end

  // count mode: anything in places 0-6 means above 999
  assign sat = (word.bcd[BCD_W-1:12] != '0);
  assign h   = sat ? 4'd9 : dg[7];
  assign t   = sat ? 4'd9 : dg[8];
  assign u   = sat ? 4'd9 : dg[9];

  always_comb begin
    if (word.mode == MODE_COUNT) begin
      segs.left_segments   = (h != 4'd0) ? seg_of_digit(h) : SEG_BLANK;
      segs.middle_segments = ((h != 4'd0) || (t != 4'd0)) ? seg_of_digit(t) : SEG_BLANK;
      segs.right_segments  = seg_of_digit(u);
    end else begin
      segs.left_segments   = t0;
      segs.middle_segments = t1;
      segs.right_segments  = t2;
    end
  end

endmodule

// ----- hdl/time_to_seven_segment_formatter.sv -----
// ----------------------------------------------------------------------------
// time_to_seven_segment_formatter: three-digit seven-segment display formatter
// Turns a microsecond time or a saturating count into three segment bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data), while in_ready, takes one word per cycle: a mode
//   bit (0 = microsecond time, 1 = count) and a 32-bit value. Result channel
//   (out_valid/out_ready/out_data) gives one word of three segment bytes per
//   input word, segments a-g in bits 0-6, decimal point in bit 7.
//   From acceptance to out_valid, eight registered shift-and-add-3 stages
//   convert 4 binary bits each into ten BCD digits, then the formatting
//   logic (lead search, rounding, points) feeds the output register in the
//   same cycle as the last stage hands over.
//   Throughput is one word per cycle while out_ready keeps the pipeline moving.
//   Every stage has its own valid bit and takes a new word when it is empty
//   or its successor moves on, so gaps close up and new words are accepted
//   while a finished result waits, until all nine registers are full.
//   When the receiver stalls, the result is held in the output register and
//   the pipeline fills behind it; in_ready drops once no stage can move.
//   Synchronous reset (rst_n low) empties every stage; no clearing pass is
//   needed since the block keeps no state between words.
// ----------------------------------------------------------------------------
module time_to_seven_segment_formatter
  import tsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tsf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tsf_out_t out_data
);

  // stage i input handshake sits at index i; index NUM_STG feeds the output
  logic [NUM_STG:0] stg_valid;
  logic [NUM_STG:0] stg_rdy;
  tsf_work_t        stg_word [NUM_STG+1];

  tsf_out_t fmt_segs;
  logic     out_valid_r, out_valid_nxt;
  tsf_out_t out_data_r;

  // launch a word: binary value in, BCD field cleared
  assign stg_valid[0]     = in_valid;
  assign stg_word[0].mode = in_data.mode;
  assign stg_word[0].bin  = in_data.value;
  assign stg_word[0].bcd  = '0;
  assign in_ready         = stg_rdy[0];

  for (genvar g = 0; g < NUM_STG; g++) begin : g_stg
    tsf_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_rdy[g]),
      .up_word  (stg_word[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_rdy[g+1]),
      .dn_word  (stg_word[g+1])
    );
  end

  // format digits straight into the output register
  tsf_format u_format (
    .word (stg_word[NUM_STG]),
    .segs (fmt_segs)
  );

  // output register advances when empty or being taken
  assign stg_rdy[NUM_STG] = !out_valid_r || out_ready;
  assign out_valid_nxt    = stg_rdy[NUM_STG] ? stg_valid[NUM_STG] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid[NUM_STG] && stg_rdy[NUM_STG]) begin
      out_data_r <= fmt_segs;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a word leaving the last conversion stage shows up at the output next cycle
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid[NUM_STG] && stg_rdy[NUM_STG]) |=> out_valid)
    else $error("converted word lost before output register");

  // the rightmost place always carries a digit in both modes
  a_right_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.right_segments[6:0] != 7'd0))
    else $error("rightmost digit blank");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // with the pipeline and output register all empty, input is taken
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ((stg_valid[NUM_STG:1] == '0) && !out_valid) |-> in_ready)
    else $error("empty pipeline refuses input");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the seven-segment display formatter
// Drives time and count words through the valid/ready input channel, with
// random gaps and output stalls. A table of directed words comes first, then
// random words shaped around the rounding and carry corners. Every result word
// is checked field by field against its typed result or the behavioral formatter here.
// ----------------------------------------------------------------------------
module testbench;
  import tsf_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_WORDS  = 650;
  localparam int IDLE_PERCENT  = 32;
  // leave slack after the last result
  localparam int SETTLE_CYCLES = 20;

  // segment patterns for digits 0..9, digit d in bits [8*d +: 8]
  localparam logic [79:0] DIGIT_GLYPHS = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef struct packed {
    tsf_in_t  word;
    logic     typed;   // 1: use the hand-written result below
    tsf_out_t want;
  } stim_row_t;

  localparam int NUM_ROWS = 24;

  // Directed words. Results are typed in only where they are obvious; the
  // rest go through the formatter below.
  localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    // count mode: blanking, saturation at 999, top bit set
    '{'{MODE_COUNT, 32'd0},          1'b1, '{8'h00, 8'h00, 8'h3F}},
    '{'{MODE_COUNT, 32'd1},          1'b1, '{8'h00, 8'h00, 8'h06}},
    '{'{MODE_COUNT, 32'd40},         1'b1, '{8'h00, 8'h66, 8'h3F}},
    '{'{MODE_COUNT, 32'd100},        1'b1, '{8'h06, 8'h3F, 8'h3F}},
    '{'{MODE_COUNT, 32'd999},        1'b1, '{8'h6F, 8'h6F, 8'h6F}},
    '{'{MODE_COUNT, 32'd1000},       1'b1, '{8'h6F, 8'h6F, 8'h6F}},
    '{'{MODE_COUNT, 32'hFFFFFFFF},   1'b1, '{8'h6F, 8'h6F, 8'h6F}},
    '{'{MODE_COUNT, 32'h80000000},   1'b1, '{8'h6F, 8'h6F, 8'h6F}},
    // time mode, no lead within the first six places: millisecond point
    '{'{MODE_TIME, 32'd0},           1'b1, '{8'hBF, 8'h3F, 8'h3F}},
    '{'{MODE_TIME, 32'd1},           1'b1, '{8'hBF, 8'h3F, 8'h3F}},
    '{'{MODE_TIME, 32'd1234},        1'b1, '{8'h86, 8'h5B, 8'h4F}},
    '{'{MODE_TIME, 32'd9995},        1'b0, '0},
    // lead at place five, with and without a carry that moves the lead
    '{'{MODE_TIME, 32'd12345},       1'b1, '{8'h06, 8'hDB, 8'h4F}},
    '{'{MODE_TIME, 32'd99950},       1'b0, '0},
    '{'{MODE_TIME, 32'd59999},       1'b0, '0},
    // lead at place four: no point at all
    '{'{MODE_TIME, 32'd123456},      1'b1, '{8'h06, 8'h5B, 8'h4F}},
    '{'{MODE_TIME, 32'd999999},      1'b0, '0},
    // seconds: two points, or only the right one with the lead at place one
    '{'{MODE_TIME, 32'd1000000},     1'b1, '{8'h86, 8'h3F, 8'hBF}},
    '{'{MODE_TIME, 32'd999499999},   1'b1, '{8'h6F, 8'h6F, 8'hEF}},
    '{'{MODE_TIME, 32'd999500000},   1'b0, '0},
    // ten-digit values: places one to three shown
    '{'{MODE_TIME, 32'd1999500000},  1'b0, '0},
    '{'{MODE_TIME, 32'hFFFFFFFF},    1'b1, '{8'h5B, 8'h6F, 8'hE6}},
    '{'{MODE_TIME, 32'h80000000},    1'b0, '0},
    '{'{MODE_TIME, 32'd4000000000},  1'b0, '0}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  tsf_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tsf_out_t out_data;

  // travel with in_data: the hand-written result of a directed word, if any
  logic     in_typed  = 1'b0;
  tsf_out_t in_want   = '0;

  // set while both sides run without gaps or stalls
  bit       steady_run = 1'b0;

  tsf_out_t pending_displays [$];
  int       error_count = 0;

  time_to_seven_segment_formatter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Behavioral formatter: three segment bytes for one input word.
  function automatic tsf_out_t format_display(input tsf_in_t w);
    int          place [0:9];
    logic [7:0]  glyph [0:9];
    int unsigned rest;
    int unsigned clipped;
    int          lead;
    int          i;
    bit          carry;
    tsf_out_t    disp;

    if (w.mode == MODE_COUNT) begin
      clipped = (w.value > 32'd999) ? 999 : w.value;
      place[0] = clipped / 100;
      place[1] = (clipped / 10) % 10;
      place[2] = clipped % 10;
      // blank the hundreds, and the tens too when both are zero
      disp.left_segments   = (place[0] != 0) ? DIGIT_GLYPHS[8*place[0] +: 8] : SEG_BLANK;
      disp.middle_segments = (place[0] != 0 || place[1] != 0) ?
                             DIGIT_GLYPHS[8*place[1] +: 8] : SEG_BLANK;
      disp.right_segments  = DIGIT_GLYPHS[8*place[2] +: 8];
      return disp;
    end

    // split into ten decimal places, place 0 most significant
    rest = w.value;
    for (i = 9; i >= 0; i--) begin
      place[i] = rest % 10;
      rest     = rest / 10;
    end

    // lead: first nonzero place among 0..5, else 6
    lead = 6;
    for (i = 5; i >= 0; i--)
      if (place[i] != 0) lead = i;

    // round to three places; a carry out of the lead moves it left, except from place zero
    if (place[lead+3] > 4) begin
      carry = 1'b1;
      for (i = lead + 2; i >= lead; i--) begin
        if (carry) begin
          if (place[i] == 9) begin
            place[i] = 0;
          end else begin
            place[i] = place[i] + 1;
            carry    = 1'b0;
          end
        end
      end
      if (carry && lead > 0) begin
        lead        = lead - 1;
        place[lead] = 1;
      end
    end

    for (i = 0; i < 10; i++)
      glyph[i] = DIGIT_GLYPHS[8*place[i] +: 8];

    if (lead == 0) lead = 1;
    if (lead < 4) begin
      glyph[3]      = glyph[3] | SEG_POINT;
      glyph[lead+2] = glyph[lead+2] | SEG_POINT;
    end else if (lead > 4) begin
      glyph[6] = glyph[6] | SEG_POINT;
    end

    disp.left_segments   = glyph[lead];
    disp.middle_segments = glyph[lead+1];
    disp.right_segments  = glyph[lead+2];
    return disp;
  endfunction

  // Receiver: stall about a third of the cycles, never during a steady run.
  always @(posedge clk) begin
    out_ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Scoreboard. All TB drives are nonblocking, so the values read here are
  // the ones the block saw at this edge. Retire the result before logging the
  // new word so a stray result can never pair with a word accepted just now.
  always @(posedge clk) begin
    tsf_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_displays.size() == 0) begin
          $error("result word %h arrived with nothing expected", out_data);
          error_count++;
        end else begin
          want = pending_displays.pop_front();
          if (out_data.left_segments !== want.left_segments) begin
            $error("left_segments: expected %h, got %h",
                   want.left_segments, out_data.left_segments);
            error_count++;
          end
          if (out_data.middle_segments !== want.middle_segments) begin
            $error("middle_segments: expected %h, got %h",
                   want.middle_segments, out_data.middle_segments);
            error_count++;
          end
          if (out_data.right_segments !== want.right_segments) begin
            $error("right_segments: expected %h, got %h",
                   want.right_segments, out_data.right_segments);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_displays.push_back(in_typed ? in_want : format_display(in_data));
    end
  end

  // Offer one word and hold it until accepted. Call and return at a rising
  // edge; valid stays high between back-to-back words.
  task automatic send_word(input tsf_in_t w, input logic typed, input tsf_out_t want);
    while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    in_typed <= typed;
    in_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_displays.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    tsf_in_t     w;
    int          n;
    int          pick;
    int          k;
    int unsigned decade;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (n = 0; n < NUM_ROWS; n++)
      send_word(DIRECTED_ROWS[n].word, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);

    // let the pipeline run dry before the random part
    drain_results();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      // a stretch in the middle with no gaps and no stalls
      steady_run = (n >= 250 && n < 350);
      // pause once more, mid-run, until everything is back
      if (n == 480) drain_results();

      pick = $urandom_range(99);
      k    = $urandom_range(3, 9);
      decade = 1;
      repeat (k) decade = decade * 10;
      if (pick < 15) begin
        // counts around the saturation point
        w.mode  = MODE_COUNT;
        w.value = $urandom_range(1100);
      end else if (pick < 22) begin
        w.mode  = MODE_COUNT;
        w.value = $urandom;
      end else if (pick < 42) begin
        // full 32-bit range: every bit toggles
        w.mode  = MODE_TIME;
        w.value = $urandom;
      end else if (pick < 70) begin
        // random magnitude up to nine digits, so leads at places one to six are hit
        w.mode  = MODE_TIME;
        w.value = $urandom_range(decade - 1);
      end else if (pick < 90) begin
        // just below a power of ten: rounding can carry through all nines
        w.mode  = MODE_TIME;
        w.value = decade - $urandom_range(1, decade / 100);
      end else begin
        // nine- and ten-digit values near the carry into place zero
        w.mode  = MODE_TIME;
        w.value = $urandom_range(999000000, 2000000000);
      end
      send_word(w, 1'b0, '0);
    end
    steady_run = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_displays.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
